>>> rtl/ctdf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctdf_pkg
// shared constants and types of the camera tracking d1 deframer
// ----------------------------------------------------------------------------
package ctdf_pkg;

    localparam int MESSAGE_BYTES = 29;
    localparam int STORE_DEPTH   = MESSAGE_BYTES - 1;
    localparam int COUNT_W       = $clog2(MESSAGE_BYTES);
    localparam int FIELD_W       = 24;

    localparam logic [7:0] SUM_START = 8'h40;

    // byte offsets of the 24-bit fields in the message
    localparam int OFS_PAN   = 2;
    localparam int OFS_TILT  = 5;
    localparam int OFS_ROLL  = 8;
    localparam int OFS_POS_X = 11;
    localparam int OFS_POS_Y = 14;
    localparam int OFS_POS_Z = 17;
    localparam int OFS_ZOOM  = 20;
    localparam int OFS_FOCUS = 23;

    typedef logic [COUNT_W-1:0] t_count;
    typedef logic [7:0]         t_byte;

    typedef struct packed {
        logic [7:0]                header;
        logic [7:0]                camera_id;
        logic signed [FIELD_W-1:0] pan;
        logic signed [FIELD_W-1:0] tilt;
        logic signed [FIELD_W-1:0] roll;
        logic signed [FIELD_W-1:0] pos_x;
        logic signed [FIELD_W-1:0] pos_y;
        logic signed [FIELD_W-1:0] pos_z;
        logic [FIELD_W-1:0]        zoom;
        logic [FIELD_W-1:0]        focus;
        logic                      checksum_ok;
    } t_result;

endpackage

>>> rtl/ctdf_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctdf interfaces
// byte input channel and decoded message output channel
// ----------------------------------------------------------------------------
interface ctdf_byte_if;
    import ctdf_pkg::*;

    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first_byte;

    modport source (output valid, output data_byte, output first_byte, input ready);
    modport sink   (input valid, input data_byte, input first_byte, output ready);
endinterface

interface ctdf_result_if;
    import ctdf_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [7:0]                header;
    logic [7:0]                camera_id;
    logic signed [FIELD_W-1:0] pan;
    logic signed [FIELD_W-1:0] tilt;
    logic signed [FIELD_W-1:0] roll;
    logic signed [FIELD_W-1:0] pos_x;
    logic signed [FIELD_W-1:0] pos_y;
    logic signed [FIELD_W-1:0] pos_z;
    logic [FIELD_W-1:0]        zoom;
    logic [FIELD_W-1:0]        focus;
    logic                      checksum_ok;

    modport source (
        output valid, output header, output camera_id, output pan, output tilt,
        output roll, output pos_x, output pos_y, output pos_z, output zoom,
        output focus, output checksum_ok, input ready
    );
    modport sink (
        input valid, input header, input camera_id, input pan, input tilt,
        input roll, input pos_x, input pos_y, input pos_z, input zoom,
        input focus, input checksum_ok, output ready
    );
endinterface

>>> rtl/camera_tracking_d1_deframer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// camera_tracking_d1_deframer_core
// a byte is registered in the input stage when accepted and absorbed when the
// output stage can take a result; the result item of a checksum byte is
// registered in the output register at the absorbing edge. throughput: one
// byte per cycle, set by the update of the byte counter, checksum and store;
// backpressure only from the output register. reset (synchronous, active low)
// empties both stages, closes any open message and restores the checksum start
// value; the byte store is not reset
// ----------------------------------------------------------------------------
module camera_tracking_d1_deframer_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    ctdf_byte_if.sink            i_byte,
    ctdf_result_if.source        o_result
);
    import ctdf_pkg::*;

    // input register stage
    logic    r_in_valid;
    t_byte   r_in_byte;
    logic    r_in_first;

    // message assembly state
    t_count  r_count,  n_count;
    t_byte   r_sum,    n_sum;
    logic    r_in_msg, n_in_msg;
    t_byte   r_store [STORE_DEPTH];

    // output register stage
    logic    r_out_valid, n_out_valid;
    t_result r_res,       n_res;

    logic    can_load;     // output register free or being emptied this cycle
    logic    take_byte;    // registered byte is absorbed this cycle
    logic    store_we;
    logic    emit;         // checksum byte closes the message
    t_count  store_idx;

    // the input stage moves whenever the output stage can take a result,
    // so a stalled output never stops bytes unless a result is waiting
    assign can_load     = !r_out_valid || o_result.ready;
    assign take_byte    = r_in_valid && can_load;
    assign i_byte.ready = !r_in_valid || can_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_byte.ready) begin
            r_in_valid <= i_byte.valid;
        end
    end

    // payload of the input stage needs no reset
    always_ff @(posedge i_clk) begin
        if (i_byte.ready && i_byte.valid) begin
            r_in_byte  <= i_byte.data_byte;
            r_in_first <= i_byte.first_byte;
        end
    end

    // per-byte update: count, running checksum and store write
    always_comb begin
        n_count   = r_count;
        n_sum     = r_sum;
        n_in_msg  = r_in_msg;
        store_we  = 1'b0;
        store_idx = r_count;
        emit      = 1'b0;
        if (take_byte) begin
            if (r_in_first) begin
                // a new first byte drops any partial message
                store_we  = 1'b1;
                store_idx = '0;
                n_sum     = SUM_START - r_in_byte;
                n_count   = t_count'(1);
                n_in_msg  = 1'b1;
            end else if (r_in_msg) begin
                if (r_count < t_count'(STORE_DEPTH)) begin
                    store_we = 1'b1;
                    n_sum    = r_sum - r_in_byte;
                    n_count  = r_count + t_count'(1);
                end else begin
                    // checksum byte: the message is complete
                    emit     = 1'b1;
                    n_sum    = SUM_START;
                    n_count  = '0;
                    n_in_msg = 1'b0;
                end
            end
            // bytes outside a message are dropped
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_sum    <= SUM_START;
            r_in_msg <= 1'b0;
        end else begin
            r_count  <= n_count;
            r_sum    <= n_sum;
            r_in_msg <= n_in_msg;
        end
    end

    // byte store, one write per cycle, read at fixed places only
    always_ff @(posedge i_clk) begin
        if (store_we) begin
            r_store[store_idx] <= r_in_byte;
        end
    end

    // result assembly: fields are big-endian byte triples
    always_comb begin
        n_res             = r_res;
        n_out_valid       = r_out_valid;
        if (o_result.ready) begin
            n_out_valid = 1'b0;
        end
        if (emit) begin
            n_out_valid       = 1'b1;
            n_res.header      = r_store[0];
            n_res.camera_id   = r_store[1];
            n_res.pan         = $signed({r_store[OFS_PAN],   r_store[OFS_PAN+1],
                                         r_store[OFS_PAN+2]});
            n_res.tilt        = $signed({r_store[OFS_TILT],  r_store[OFS_TILT+1],
                                         r_store[OFS_TILT+2]});
            n_res.roll        = $signed({r_store[OFS_ROLL],  r_store[OFS_ROLL+1],
                                         r_store[OFS_ROLL+2]});
            n_res.pos_x       = $signed({r_store[OFS_POS_X], r_store[OFS_POS_X+1],
                                         r_store[OFS_POS_X+2]});
            n_res.pos_y       = $signed({r_store[OFS_POS_Y], r_store[OFS_POS_Y+1],
                                         r_store[OFS_POS_Y+2]});
            n_res.pos_z       = $signed({r_store[OFS_POS_Z], r_store[OFS_POS_Z+1],
                                         r_store[OFS_POS_Z+2]});
            n_res.zoom        = {r_store[OFS_ZOOM],  r_store[OFS_ZOOM+1],
                                 r_store[OFS_ZOOM+2]};
            n_res.focus       = {r_store[OFS_FOCUS], r_store[OFS_FOCUS+1],
                                 r_store[OFS_FOCUS+2]};
            n_res.checksum_ok = (r_sum == r_in_byte);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    // output channel
    assign o_result.valid       = r_out_valid;
    assign o_result.header      = r_res.header;
    assign o_result.camera_id   = r_res.camera_id;
    assign o_result.pan         = r_res.pan;
    assign o_result.tilt        = r_res.tilt;
    assign o_result.roll        = r_res.roll;
    assign o_result.pos_x       = r_res.pos_x;
    assign o_result.pos_y       = r_res.pos_y;
    assign o_result.pos_z       = r_res.pos_z;
    assign o_result.zoom        = r_res.zoom;
    assign o_result.focus       = r_res.focus;
    assign o_result.checksum_ok = r_res.checksum_ok;

endmodule

>>> rtl/ctdf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctdf_checker
// port-level checks of the deframer, attached by bind
// ----------------------------------------------------------------------------
module ctdf_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_valid,
    input logic                                i_in_ready,
    input logic                                i_out_valid,
    input logic                                i_out_ready,
    input logic [7:0]                          i_header,
    input logic signed [ctdf_pkg::FIELD_W-1:0] i_pan,
    input logic                                i_checksum_ok
);
    import ctdf_pkg::*;

    // nothing shows on the output in the cycle after reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // a waiting result holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_header) && $stable(i_pan) && $stable(i_checksum_ok))
        else $error("result dropped or changed while stalled");

    // no backpressure on bytes while the output side is free
    a_ready_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_out_valid || i_out_ready) |-> i_in_ready)
        else $error("input stalled with free output");

    // a new result follows an accepted byte that passed the input and output registers
    a_result_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(i_in_valid && i_in_ready, 2))
        else $error("result without a preceding byte");

endmodule

bind camera_tracking_d1_deframer_core ctdf_checker u_ctdf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_byte.valid),
    .i_in_ready    (i_byte.ready),
    .i_out_valid   (o_result.valid),
    .i_out_ready   (o_result.ready),
    .i_header      (o_result.header),
    .i_pan         (o_result.pan),
    .i_checksum_ok (o_result.checksum_ok)
);

>>> dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for camera_tracking_d1_deframer_core: bytes of tracking
// messages go in with random gaps, a software copy of the deframer predicts
// each decoded message, and every result item is compared field by field
// ----------------------------------------------------------------------------
module tb;
    import ctdf_pkg::*;

    typedef struct packed {
        t_byte data;
        logic  first;
    } t_link_byte;

    // number of message-carrying bytes the random part aims for
    localparam int TARGET_BYTES = 1600;
    // receiver hold-off length and the window with no idling at all
    localparam int HOLD_CYCLES  = 400;
    localparam int CALM_FROM    = 1000;
    localparam int CALM_TO      = 1600;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    ctdf_byte_if   byte_if ();
    ctdf_result_if res_if ();

    camera_tracking_d1_deframer_core uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_byte   (byte_if),
        .o_result (res_if)
    );

    always #5 i_clk = ~i_clk;

    // stimulus and expectation stores
    t_link_byte pending_bytes[$];
    t_result    expected_msgs[$];

    // shadow deframer state, advanced on every accepted byte
    t_byte msg_bytes [STORE_DEPTH];
    t_byte msg_sum   = SUM_START;
    int    msg_count = 0;
    logic  msg_open  = 1'b0;

    int fail_count   = 0;
    int results_seen = 0;
    int cycle_no     = 0;
    int stall_left   = 0;
    bit stall_done   = 1'b0;
    bit calm;

    // ------------------------------------------------------------------------
    // shadow deframer
    // ------------------------------------------------------------------------

    // big-endian 24-bit field starting at a store offset
    function automatic logic [FIELD_W-1:0] triple(input int at);
        return {msg_bytes[at], msg_bytes[at+1], msg_bytes[at+2]};
    endfunction

    // take one byte; returns 1 with the decoded message when the checksum
    // byte closes a message
    function automatic bit absorb_byte(input t_byte b, input logic first,
                                       output t_result msg);
        msg = '0;
        // a first byte always restarts, dropping any partial message
        if (first) begin
            msg_bytes[0] = b;
            msg_sum      = SUM_START - b;
            msg_count    = 1;
            msg_open     = 1'b1;
            return 1'b0;
        end
        // stray byte with no message open
        if (!msg_open)
            return 1'b0;
        if (msg_count < STORE_DEPTH) begin
            msg_bytes[msg_count] = b;
            msg_sum              = msg_sum - b;
            msg_count            = msg_count + 1;
            return 1'b0;
        end
        // checksum byte: decode and close
        msg.header      = msg_bytes[0];
        msg.camera_id   = msg_bytes[1];
        msg.pan         = triple(OFS_PAN);
        msg.tilt        = triple(OFS_TILT);
        msg.roll        = triple(OFS_ROLL);
        msg.pos_x       = triple(OFS_POS_X);
        msg.pos_y       = triple(OFS_POS_Y);
        msg.pos_z       = triple(OFS_POS_Z);
        msg.zoom        = triple(OFS_ZOOM);
        msg.focus       = triple(OFS_FOCUS);
        msg.checksum_ok = (msg_sum == b);
        msg_open  = 1'b0;
        msg_count = 0;
        msg_sum   = SUM_START;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    task automatic queue_byte(input t_byte b, input logic first);
        t_link_byte item;
        item.data  = b;
        item.first = first;
        pending_bytes.push_back(item);
    endtask

    // queue the first 'keep' bytes of a message; a full message gets its
    // checksum byte appended, corrupted on request
    task automatic queue_message(input t_byte body [STORE_DEPTH], input bit corrupt,
                                 input int keep);
        t_byte sum;
        sum = SUM_START;
        for (int i = 0; i < STORE_DEPTH; i++) begin
            sum = sum - body[i];
            if (i < keep)
                queue_byte(body[i], i == 0);
        end
        if (keep >= MESSAGE_BYTES) begin
            if (corrupt)
                sum = sum + t_byte'($urandom_range(1, 255));
            queue_byte(sum, 1'b0);
        end
    endtask

    // content byte biased toward the field extremes
    function automatic t_byte field_byte();
        case ($urandom_range(9))
            0: return 8'h00;
            1: return 8'hff;
            2: return 8'h80;
            3: return 8'h7f;
            default: return t_byte'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // stimulus, then end of run
    // ------------------------------------------------------------------------
    initial begin
        t_byte body [STORE_DEPTH];
        int    counted;
        int    pick;
        int    keep;

        // known values on every input before the first edge
        byte_if.valid      = 1'b0;
        byte_if.data_byte  = 8'h00;
        byte_if.first_byte = 1'b0;
        res_if.ready       = 1'b0;

        // directed: stray bytes before any message start
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hff, 1'b0);
        // a partial message cut short by a new first byte
        queue_byte(8'hd1, 1'b1);
        queue_byte(8'h01, 1'b0);
        queue_byte(8'h02, 1'b0);
        // full message with the signed and unsigned extremes, good checksum
        body = '{8'hd1, 8'hff,
                 8'h7f, 8'hff, 8'hff,   8'h80, 8'h00, 8'h00,   8'hff, 8'hff, 8'hff,
                 8'h00, 8'h00, 8'h00,   8'h00, 8'h00, 8'h01,   8'h80, 8'h00, 8'h01,
                 8'hff, 8'hff, 8'hff,   8'h00, 8'h00, 8'h00,
                 8'h55, 8'haa};
        queue_message(body, 1'b0, MESSAGE_BYTES);
        // byte after the checksum byte is ignored
        queue_byte(8'h12, 1'b0);

        // random: mostly well-formed messages, some corrupted or cut short,
        // and a little noise between them
        counted = 0;
        while (counted < TARGET_BYTES) begin
            foreach (body[i])
                body[i] = field_byte();
            pick = $urandom_range(99);
            if (pick < 78) begin
                queue_message(body, 1'b0, MESSAGE_BYTES);
                counted += MESSAGE_BYTES;
            end else if (pick < 88) begin
                queue_message(body, 1'b1, MESSAGE_BYTES);
                counted += MESSAGE_BYTES;
            end else if (pick < 94) begin
                // the next message's first byte cuts this one off
                keep = $urandom_range(1, STORE_DEPTH);
                queue_message(body, 1'b0, keep);
                counted += keep;
            end else begin
                // message followed by bytes that no message claims
                queue_message(body, $urandom_range(1) != 0, MESSAGE_BYTES);
                counted += MESSAGE_BYTES;
                repeat ($urandom_range(1, 3))
                    queue_byte(t_byte'($urandom), 1'b0);
            end
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // all bytes handed over and accepted
        do @(negedge i_clk);
        while (pending_bytes.size() != 0 || byte_if.valid);

        // let the last results drain, bounded
        for (int n = 0; n < 5000 && expected_msgs.size() != 0; n++)
            @(negedge i_clk);
        repeat (10) @(negedge i_clk);

        if (expected_msgs.size() != 0) begin
            $error("%0d expected result items never arrived", expected_msgs.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("camera_tracking_d1_deframer_core: match");
        end else begin
            $display("camera_tracking_d1_deframer_core: mismatch");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("camera_tracking_d1_deframer_core: mismatch");
        $finish;
    end

    // ------------------------------------------------------------------------
    // pacing: cycle count, calm window and receiver hold-off
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        cycle_no <= cycle_no + 1;
    end

    assign calm = (cycle_no >= CALM_FROM) && (cycle_no < CALM_TO);

    // once a few messages have come out, the receiver holds off long enough
    // for the output stage to fill and the input to stall
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stall_left <= 0;
        end else if (!stall_done && results_seen == 4) begin
            stall_left <= HOLD_CYCLES;
            stall_done <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
        end
    end

    // ------------------------------------------------------------------------
    // byte driver: predicts on acceptance, then offers the next item
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : byte_driver
        t_link_byte item;
        t_result    msg;
        if (!i_rst_n) begin
            byte_if.valid <= 1'b0;
        end else begin
            if (byte_if.valid && byte_if.ready) begin
                if (absorb_byte(byte_if.data_byte, byte_if.first_byte, msg))
                    expected_msgs.push_back(msg);
            end
            // a held item stays put until taken; otherwise maybe idle
            if (!byte_if.valid || byte_if.ready) begin
                if (pending_bytes.size() != 0 &&
                    (calm || stall_left > 0 || $urandom_range(99) >= 25)) begin
                    item = pending_bytes.pop_front();
                    byte_if.data_byte  <= item.data;
                    byte_if.first_byte <= item.first;
                    byte_if.valid      <= 1'b1;
                end else begin
                    byte_if.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // result monitor: checks each accepted item against the oldest prediction
    // ------------------------------------------------------------------------
    task automatic check_field(input string name, input logic [FIELD_W-1:0] want,
                               input logic [FIELD_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : result_monitor
        t_result want;
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                results_seen <= results_seen + 1;
                if (expected_msgs.size() == 0) begin
                    $error("result item with no message expected");
                    fail_count++;
                end else begin
                    want = expected_msgs.pop_front();
                    check_field("header",      FIELD_W'(want.header),
                                FIELD_W'(res_if.header));
                    check_field("camera_id",   FIELD_W'(want.camera_id),
                                FIELD_W'(res_if.camera_id));
                    check_field("pan",         want.pan,         res_if.pan);
                    check_field("tilt",        want.tilt,        res_if.tilt);
                    check_field("roll",        want.roll,        res_if.roll);
                    check_field("pos_x",       want.pos_x,       res_if.pos_x);
                    check_field("pos_y",       want.pos_y,       res_if.pos_y);
                    check_field("pos_z",       want.pos_z,       res_if.pos_z);
                    check_field("zoom",        want.zoom,        res_if.zoom);
                    check_field("focus",       want.focus,       res_if.focus);
                    check_field("checksum_ok", FIELD_W'(want.checksum_ok),
                                FIELD_W'(res_if.checksum_ok));
                end
            end
            // hold-off wins; otherwise stall about a quarter of the time outside the calm window
            res_if.ready <= (stall_left == 0) && (calm || $urandom_range(99) >= 25);
        end
    end

endmodule

>>> sim.f
rtl/ctdf_pkg.sv
rtl/ctdf_if.sv
rtl/camera_tracking_d1_deframer_core.sv
rtl/ctdf_checker.sv
dv/tb.sv
